FILE: design/lfu_pkg.sv
// Package with the shared types and constants of the LFU cache table.
`timescale 1ns / 1ps

package lfu_pkg;

    // Default table depth.
    localparam int EntriesDefault = 16;

    // Capacity register reset value and width.
    localparam int CapWidth = 5;
    localparam logic [CapWidth-1:0] CapReset = 5'd16;

    // Request kinds.
    localparam logic KindGet = 1'b0;
    localparam logic KindPut = 1'b1;

    // Input item of the lookup channel.
    typedef struct packed {
        logic               kind;
        logic signed [31:0] key;
        logic signed [31:0] value;
    } t_req;

    // Result item of the response channel.
    typedef struct packed {
        logic               hit;
        logic signed [31:0] read_value;
        logic               evicted;
        logic signed [31:0] evicted_key;
    } t_rsp;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture the request and start the key match
        logic scan;      // step the victim and free slot search
        logic commit;    // update the table and build the result
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_done; // the scan pointer is on the last entry
    } t_sts;

endpackage

FILE: design/lfu_cache_table_core.sv
// Top level of the LFU cache table with least-recently-used tie breaking.
`timescale 1ns / 1ps
//
// Channel   Direction  Handshake                  Payload
// request   in         i_req_valid / o_req_ready  i_req  (kind, key, value)
// response  out        o_rsp_valid / i_rsp_ready  o_rsp  (hit, read_value, evicted, evicted_key)
// config    in         i_cfg_we                   i_cfg_wdata (capacity)
//
// Each request passes a load step for the key match, the victim and free slot
// scan over all ENTRIES entries (one entry a cycle), and a commit.
// A new request is taken in the cycle its predecessor's response transfers.
// A stalled response holds the block; reset is synchronous, active low.

module lfu_cache_table_core #(
    parameter int ENTRIES = lfu_pkg::EntriesDefault
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [lfu_pkg::CapWidth-1:0]  i_cfg_wdata,
    input  logic                          i_req_valid,
    output logic                          o_req_ready,
    input  lfu_pkg::t_req                 i_req,
    output logic                          o_rsp_valid,
    input  logic                          i_rsp_ready,
    output lfu_pkg::t_rsp                 o_rsp
);

    lfu_pkg::t_cmd cmd;
    lfu_pkg::t_sts sts;

    lfu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    lfu_dpath #(.ENTRIES(ENTRIES)) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (i_req),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_rsp       (o_rsp)
    );

endmodule

FILE: design/lfu_ctrl.sv
// Controller state machine of the LFU cache table.
`timescale 1ns / 1ps

module lfu_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_ready,
    output logic          o_rsp_valid,
    input  logic          i_rsp_ready,
    output lfu_pkg::t_cmd o_cmd,
    input  lfu_pkg::t_sts i_sts
);

    localparam logic [1:0] StIdle = 2'd0;
    localparam logic [1:0] StScan = 2'd1;
    localparam logic [1:0] StDone = 2'd2;
    localparam logic [1:0] StOut  = 2'd3;

    logic [1:0] r_state, n_state;
    logic       req_xfer;

    // A new request is taken when idle, or when the result is being taken.
    assign o_req_ready = (r_state == StIdle) || (r_state == StOut && i_rsp_ready);
    assign req_xfer    = i_req_valid && o_req_ready;
    assign o_rsp_valid = (r_state == StOut);

    // Command decode.
    always_comb begin
        o_cmd        = '0;
        o_cmd.load   = req_xfer;
        o_cmd.scan   = (r_state == StScan);
        o_cmd.commit = (r_state == StDone);
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            StIdle: if (req_xfer) n_state = StScan;
            StScan: if (i_sts.scan_done) n_state = StDone;
            StDone: n_state = StOut;
            StOut: begin
                if (req_xfer) n_state = StScan;
                else if (i_rsp_ready) n_state = StIdle;
            end
            default: n_state = StIdle;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= StIdle;
        else r_state <= n_state;
    end

`ifndef SYNTHESIS
    // A commit always follows the scan.
    a_commit_after_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == StScan && i_sts.scan_done) |=> o_cmd.commit)
        else $error("commit missing after scan");
    // A result appears in the cycle after the commit.
    a_rsp_after_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |=> o_rsp_valid)
        else $error("result missing after commit");
    // No request is taken while the search runs.
    a_no_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == StScan || r_state == StDone) |-> !o_cmd.load)
        else $error("request taken while busy");
`endif

endmodule

FILE: design/lfu_dpath.sv
// Datapath of the LFU cache table: entry table, key match, victim search, update.
`timescale 1ns / 1ps

module lfu_dpath #(
    parameter int ENTRIES = lfu_pkg::EntriesDefault
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [lfu_pkg::CapWidth-1:0]      i_cfg_wdata,
    input  lfu_pkg::t_req                     i_req,
    input  lfu_pkg::t_cmd                     i_cmd,
    output lfu_pkg::t_sts                     o_sts,
    output lfu_pkg::t_rsp                     o_rsp
);

    localparam int IdxW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CntW  = $clog2(ENTRIES + 1);

    // Entry table.
    logic [ENTRIES-1:0]   r_valid;
    logic [31:0]          r_key   [ENTRIES];
    logic [31:0]          r_data  [ENTRIES];
    logic [31:0]          r_count [ENTRIES];
    logic [IdxW-1:0]      r_rank  [ENTRIES];
    logic [CntW-1:0]      r_fill;
    logic [lfu_pkg::CapWidth-1:0] r_cap;

    // Captured request and search results.
    lfu_pkg::t_req        r_req;
    logic [ENTRIES-1:0]   r_match;
    logic [IdxW-1:0]      r_idx, r_vict, r_free;
    logic                 r_vfound, r_ffound;
    lfu_pkg::t_rsp        r_rsp;

    logic [ENTRIES-1:0]   match;
    logic                 hit;
    logic [IdxW-1:0]      hit_idx;
    logic [CntW-1:0]      cap_eff;
    logic                 better;

    // Capacity register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_cap <= lfu_pkg::CapReset;
        else if (i_cfg_we) r_cap <= i_cfg_wdata;
    end

    // Effective capacity is clipped to the table depth.
    always_comb begin
        if (32'(r_cap) > 32'(ENTRIES)) cap_eff = CntW'(ENTRIES);
        else cap_eff = CntW'(r_cap);
    end

    // Parallel key match on the request being loaded.
    always_comb begin
        for (int i = 0; i < ENTRIES; i++)
            match[i] = r_valid[i] && (r_key[i] == i_req.key);
    end

    // Hit index from the registered one-hot match.
    always_comb begin
        hit_idx = '0;
        for (int i = 0; i < ENTRIES; i++)
            if (r_match[i]) hit_idx = IdxW'(i);
    end
    assign hit = |r_match;

    // Candidate at the scan pointer beats the current victim.
    assign better = !r_vfound || (r_count[r_idx] < r_count[r_vict]) ||
                    (r_count[r_idx] == r_count[r_vict] && r_rank[r_idx] > r_rank[r_vict]);

    assign o_sts.scan_done = (32'(r_idx) == ENTRIES - 1);

    // Request capture and one-entry-a-cycle victim and free slot scan.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req    <= i_req;
            r_match  <= match;
            r_idx    <= '0;
            r_vfound <= 1'b0;
            r_ffound <= 1'b0;
            r_vict   <= '0;
            r_free   <= '0;
        end else if (i_cmd.scan) begin
            if (r_valid[r_idx]) begin
                if (better) begin
                    r_vict   <= r_idx;
                    r_vfound <= 1'b1;
                end
            end else if (!r_ffound) begin
                r_free   <= r_idx;
                r_ffound <= 1'b1;
            end
            if (!o_sts.scan_done) r_idx <= r_idx + 1'b1;
        end
    end

    // Table update and result formation.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_fill  <= '0;
        end else if (i_cmd.commit) begin
            r_rsp.hit         <= hit;
            r_rsp.read_value  <= 32'sd0;
            r_rsp.evicted     <= 1'b0;
            r_rsp.evicted_key <= 32'sd0;
            if (r_req.kind == lfu_pkg::KindGet) begin
                if (hit) begin
                    r_rsp.read_value <= r_data[hit_idx];
                    for (int i = 0; i < ENTRIES; i++)
                        if (r_valid[i] && r_rank[i] < r_rank[hit_idx])
                            r_rank[i] <= r_rank[i] + 1'b1;
                    r_rank[hit_idx] <= '0;
                    if (r_count[hit_idx] != '1) r_count[hit_idx] <= r_count[hit_idx] + 1;
                end else begin
                    r_rsp.read_value <= -32'sd1;
                end
            end else if (cap_eff != '0) begin
                if (hit) begin
                    r_data[hit_idx] <= r_req.value;
                    for (int i = 0; i < ENTRIES; i++)
                        if (r_valid[i] && r_rank[i] < r_rank[hit_idx])
                            r_rank[i] <= r_rank[i] + 1'b1;
                    r_rank[hit_idx] <= '0;
                    if (r_count[hit_idx] != '1) r_count[hit_idx] <= r_count[hit_idx] + 1;
                end else if (r_fill >= cap_eff && r_vfound) begin
                    // Evict, then reuse the victim slot; ranks above it stay put,
                    // ranks below it shift up by one.
                    r_rsp.evicted     <= 1'b1;
                    r_rsp.evicted_key <= r_key[r_vict];
                    for (int i = 0; i < ENTRIES; i++)
                        if (r_valid[i] && r_rank[i] < r_rank[r_vict])
                            r_rank[i] <= r_rank[i] + 1'b1;
                    r_key[r_vict]   <= r_req.key;
                    r_data[r_vict]  <= r_req.value;
                    r_count[r_vict] <= 32'd1;
                    r_rank[r_vict]  <= '0;
                end else if (r_ffound) begin
                    for (int i = 0; i < ENTRIES; i++)
                        if (r_valid[i]) r_rank[i] <= r_rank[i] + 1'b1;
                    r_valid[r_free] <= 1'b1;
                    r_key[r_free]   <= r_req.key;
                    r_data[r_free]  <= r_req.value;
                    r_count[r_free] <= 32'd1;
                    r_rank[r_free]  <= '0;
                    r_fill          <= r_fill + 1'b1;
                end
            end
        end
    end

    assign o_rsp = r_rsp;

`ifndef SYNTHESIS
    // The fill count follows the number of valid entries.
    a_fill_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'($countones(r_valid)) == 32'(r_fill))
        else $error("fill count mismatch");
    // A key is never held twice.
    a_unique_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |-> $onehot0(r_match))
        else $error("duplicate key");
    // An eviction only reports on a put.
    a_evict_put: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_cmd.commit) && r_rsp.evicted |-> r_req.kind == lfu_pkg::KindPut)
        else $error("eviction on get");
`endif

endmodule
